// File: rtl/vic_pkg.sv
// ----------------------------------------------------------------------------
// vic_pkg: shared definitions of the vectored interrupt controller
// Item kinds, register word map, identification bytes and the command
// bundle from the controller to the datapath.
// ----------------------------------------------------------------------------
package vic_pkg;

  localparam int unsigned NUM_VECTORS_DEF = 16;

  typedef enum logic [1:0] {
    KIND_LINE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2,
    KIND_NONE  = 2'd3
  } kind_e;

  // Word addresses (byte offset >> 2)
  localparam logic [9:0] W_IRQ_STATUS = 10'h000;
  localparam logic [9:0] W_FIQ_STATUS = 10'h001;
  localparam logic [9:0] W_RAW        = 10'h002;
  localparam logic [9:0] W_FIQ_SEL    = 10'h003;
  localparam logic [9:0] W_ENABLE     = 10'h004;
  localparam logic [9:0] W_ENABLE_CLR = 10'h005;
  localparam logic [9:0] W_SOFT       = 10'h006;
  localparam logic [9:0] W_SOFT_CLR   = 10'h007;
  localparam logic [9:0] W_PROTECT    = 10'h008;
  localparam logic [9:0] W_VECTADDR   = 10'h00C;
  localparam logic [9:0] W_DEF_VECT   = 10'h00D;
  localparam logic [9:0] W_TEST_CTRL  = 10'h0C0;
  localparam logic [9:0] W_VADDR_BASE = 10'h040;
  localparam logic [9:0] W_VCTRL_BASE = 10'h080;
  localparam logic [9:0] W_ID_BASE    = 10'h3F8;

  // Vector control fields
  localparam int unsigned CTRL_EN_BIT = 5;

  localparam logic [7:0] ID_BYTES [8] = '{
    8'h90, 8'h11, 8'h04, 8'h00, 8'h0D, 8'hF0, 8'h05, 8'hB1
  };

  typedef struct packed {
    logic capture;  // latch the incoming item
    logic eval;     // register the vector hit vector
    logic apply;    // perform the access, update state
    logic report;   // register IRQ/FIQ from updated state
  } vic_cmd_t;

endpackage

// File: rtl/vectored_interrupt_controller.sv
// ----------------------------------------------------------------------------
// vectored_interrupt_controller: 32-line vectored interrupt controller
// Line changes and register reads/writes enter as items; each item
// returns read data, the IRQ/FIQ outputs and a bad-offset flag.
// ----------------------------------------------------------------------------
//
//  channel | handshake          | payload
//  --------+--------------------+--------------------------------------------
//  item in | start / busy       | kind_i, offset_i, write_data_i,
//          |                    | line_index_i, line_level_i
//  result  | done_o (1 cycle)   | read_data_o, irq_out_o, fiq_out_o,
//          |                    | bad_offset_o
//
//  An item is taken at a clock edge with start high and busy low. It then
//  steps through evaluate (vector hits registered), apply (access and state
//  update), report (IRQ/FIQ registered), then the strobe. The next item may
//  be accepted in the strobe cycle, so a new item is taken only once the
//  last one has finished. The result cannot be stalled. After reset all masks
//  and vectors are zero and no level is active; no clearing pass is needed.
//
// ----------------------------------------------------------------------------
module vectored_interrupt_controller
  import vic_pkg::*;
#(
  parameter int unsigned NumVectors = NUM_VECTORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind_i,
  input  logic [11:0] offset_i,
  input  logic [31:0] write_data_i,
  input  logic [4:0]  line_index_i,
  input  logic        line_level_i,
  output logic        done_o,
  output logic [31:0] read_data_o,
  output logic        irq_out_o,
  output logic        fiq_out_o,
  output logic        bad_offset_o
);

  vic_cmd_t cmd;

  // sequencer: one item at a time, fixed four-step walk
  vic_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  // state, decode, priority search and flags
  vic_datapath #(
    .NumVectors (NumVectors)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .kind_i       (kind_i),
    .offset_i     (offset_i),
    .write_data_i (write_data_i),
    .line_index_i (line_index_i),
    .line_level_i (line_level_i),
    .read_data_o  (read_data_o),
    .irq_out_o    (irq_out_o),
    .fiq_out_o    (fiq_out_o),
    .bad_offset_o (bad_offset_o)
  );

endmodule

// File: rtl/vic_ctrl.sv
// ----------------------------------------------------------------------------
// vic_ctrl: item sequencer
// Steps each item through evaluate, apply and report, then strobes done.
// ----------------------------------------------------------------------------
module vic_ctrl
  import vic_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  output logic     done_o,
  output vic_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_APPLY,
    ST_REPORT
  } state_e;

  state_e state_q;
  logic   busy_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: begin
          if (start) begin
            state_q <= ST_EVAL;
            busy_q  <= 1'b1;
          end
        end
        ST_EVAL:  state_q <= ST_APPLY;
        ST_APPLY: state_q <= ST_REPORT;
        ST_REPORT: begin
          state_q <= ST_IDLE;
          busy_q  <= 1'b0;
          done_q  <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.capture = (state_q == ST_IDLE) && start;
    cmd_o.eval    = (state_q == ST_EVAL);
    cmd_o.apply   = (state_q == ST_APPLY);
    cmd_o.report  = (state_q == ST_REPORT);
  end

  assign busy   = busy_q;
  assign done_o = done_q;

endmodule

// File: rtl/vic_datapath.sv
// ----------------------------------------------------------------------------
// vic_datapath: register file, priority search and output flags
// Holds all controller state and performs one step per command.
// ----------------------------------------------------------------------------
module vic_datapath
  import vic_pkg::*;
#(
  parameter int unsigned NumVectors = NUM_VECTORS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  vic_cmd_t    cmd_i,
  input  logic [1:0]  kind_i,
  input  logic [11:0] offset_i,
  input  logic [31:0] write_data_i,
  input  logic [4:0]  line_index_i,
  input  logic        line_level_i,
  output logic [31:0] read_data_o,
  output logic        irq_out_o,
  output logic        fiq_out_o,
  output logic        bad_offset_o
);

  localparam int unsigned NumLevels = NumVectors + 1;
  localparam int unsigned LW = $clog2(NumLevels + 1);
  localparam int unsigned IW = $clog2(NumLevels);
  localparam int unsigned CW = (NumVectors > 1) ? $clog2(NumVectors) : 1;
  localparam logic [LW-1:0] LevelNone = LW'(NumLevels);
  localparam logic [IW-1:0] DefIdx    = IW'(NumVectors);
  localparam logic [9:0]    VecSpan   = 10'(NumVectors);

  // captured item
  kind_e       kind_q;
  logic [9:0]  word_q;
  logic [31:0] wdata_q;
  logic [4:0]  line_q;
  logic        level_q;

  // controller state
  logic [31:0] raw_q, soft_q, en_q, fiqm_q;
  logic        prot_q;
  logic [7:0]  ctrl_q  [NumVectors];
  logic [31:0] vaddr_q [NumLevels];
  logic [LW-1:0] saved_q [NumLevels];
  logic [LW-1:0] cur_q;
  logic [NumLevels-1:0] hit_q;

  logic [31:0] rdata_q;
  logic        bad_q, irq_q, fiq_q;

  logic [31:0] all_lines, irqs;
  assign all_lines = raw_q | soft_q;
  assign irqs      = all_lines & en_q & ~fiqm_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      kind_q  <= kind_e'(kind_i);
      word_q  <= offset_i[11:2];
      wdata_q <= write_data_i;
      line_q  <= line_index_i;
      level_q <= line_level_i;
    end
  end

  // A vector level hits when it is enabled and its selected source line is active; the default level hits on any line.
  logic [NumLevels-1:0] hit_d;
  always_comb begin
    for (int k = 0; k < NumVectors; k++) begin
      hit_d[k] = ctrl_q[k][CTRL_EN_BIT] & all_lines[ctrl_q[k][4:0]];
    end
    hit_d[NumVectors] = |all_lines;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) hit_q <= hit_d;
  end

  logic [LW-1:0] first_lvl;
  always_comb begin
    first_lvl = LevelNone;
    for (int l = NumLevels - 1; l >= 0; l--) begin
      if (hit_q[l]) first_lvl = LW'(l);
    end
  end

  // address decode
  logic          is_id, in_vaddr, in_vctrl;
  logic [IW-1:0] vsel;
  logic [CW-1:0] csel;
  logic [9:0]    vrel, crel;
  assign vrel     = word_q - W_VADDR_BASE;
  assign crel     = word_q - W_VCTRL_BASE;
  assign is_id    = word_q >= W_ID_BASE;
  assign in_vaddr = (word_q >= W_VADDR_BASE) && (word_q < W_VADDR_BASE + VecSpan);
  assign in_vctrl = (word_q >= W_VCTRL_BASE) && (word_q < W_VCTRL_BASE + VecSpan);
  assign vsel     = vrel[IW-1:0];
  assign csel     = crel[CW-1:0];

  // apply step
  logic [31:0]   rdata_d;
  logic          bad_d;
  logic [31:0]   raw_d, soft_d, en_d, fiqm_d;
  logic          prot_d;
  logic [LW-1:0] cur_d, prev_lvl;
  logic          use_vaddr;
  logic [IW-1:0] vaddr_ridx, vaddr_widx, saved_widx;
  logic          vaddr_we, ctrl_we, saved_we;

  assign prev_lvl = saved_q[cur_q[IW-1:0]];

  always_comb begin
    rdata_d    = '0;
    bad_d      = 1'b0;
    raw_d      = raw_q;
    soft_d     = soft_q;
    en_d       = en_q;
    fiqm_d     = fiqm_q;
    prot_d     = prot_q;
    cur_d      = cur_q;
    use_vaddr  = 1'b0;
    vaddr_ridx = '0;
    vaddr_widx = vsel;
    vaddr_we   = 1'b0;
    ctrl_we    = 1'b0;
    saved_we   = 1'b0;
    saved_widx = first_lvl[IW-1:0];
    unique case (kind_q)
      KIND_LINE: raw_d[line_q] = level_q;
      KIND_READ: begin
        if (is_id) begin
          rdata_d = 32'(ID_BYTES[word_q[2:0]]);
        end else if (in_vaddr) begin
          use_vaddr  = 1'b1;
          vaddr_ridx = vsel;
        end else if (in_vctrl) begin
          rdata_d = 32'(ctrl_q[csel]);
        end else begin
          unique case (word_q)
            W_IRQ_STATUS: rdata_d = irqs;
            W_FIQ_STATUS: rdata_d = all_lines & fiqm_q;
            W_RAW:        rdata_d = all_lines;
            W_FIQ_SEL:    rdata_d = fiqm_q;
            W_ENABLE:     rdata_d = en_q;
            W_SOFT:       rdata_d = soft_q;
            W_PROTECT:    rdata_d = 32'(prot_q);
            W_VECTADDR: begin
              use_vaddr = 1'b1;
              if (first_lvl < cur_q) begin
                // raise to the pending level, push the old one
                saved_we   = 1'b1;
                cur_d      = first_lvl;
                vaddr_ridx = first_lvl[IW-1:0];
              end else if (cur_q == LevelNone) begin
                vaddr_ridx = DefIdx;
              end else begin
                vaddr_ridx = cur_q[IW-1:0];
              end
            end
            W_DEF_VECT: begin
              use_vaddr  = 1'b1;
              vaddr_ridx = DefIdx;
            end
            default: bad_d = 1'b1;
          endcase
        end
      end
      KIND_WRITE: begin
        if (in_vaddr) begin
          vaddr_we = 1'b1;
        end else if (in_vctrl) begin
          ctrl_we = 1'b1;
        end else begin
          unique case (word_q)
            W_IRQ_STATUS: ;
            W_FIQ_SEL:    fiqm_d = wdata_q;
            W_ENABLE:     en_d   = en_q | wdata_q;
            W_ENABLE_CLR: en_d   = en_q & ~wdata_q;
            W_SOFT:       soft_d = soft_q | wdata_q;
            W_SOFT_CLR:   soft_d = soft_q & ~wdata_q;
            W_PROTECT:    prot_d = wdata_q[0];
            W_VECTADDR: begin
              // pop the saved level
              if (cur_q < LevelNone) begin
                cur_d = (prev_lvl <= LevelNone) ? prev_lvl : LevelNone;
              end
            end
            W_DEF_VECT: begin
              vaddr_we   = 1'b1;
              vaddr_widx = DefIdx;
            end
            W_TEST_CTRL: ;
            default: bad_d = 1'b1;
          endcase
        end
      end
      KIND_NONE: ;
      default: ;
    endcase
    if (use_vaddr) rdata_d = vaddr_q[vaddr_ridx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      raw_q  <= '0;
      soft_q <= '0;
      en_q   <= '0;
      fiqm_q <= '0;
      prot_q <= 1'b0;
      cur_q  <= LevelNone;
      for (int k = 0; k < NumVectors; k++) ctrl_q[k] <= '0;
      for (int k = 0; k < NumLevels; k++) vaddr_q[k] <= '0;
    end else if (cmd_i.apply) begin
      raw_q  <= raw_d;
      soft_q <= soft_d;
      en_q   <= en_d;
      fiqm_q <= fiqm_d;
      prot_q <= prot_d;
      cur_q  <= cur_d;
      if (ctrl_we) ctrl_q[csel] <= wdata_q[7:0];
      if (vaddr_we) vaddr_q[vaddr_widx] <= wdata_q;
    end
  end

  // saved-level stack has no reset: every pop reads a pushed entry
  always_ff @(posedge clk_i) begin
    if (cmd_i.apply && saved_we) saved_q[saved_widx] <= cur_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.apply) begin
      rdata_q <= rdata_d;
      bad_q   <= bad_d;
    end
  end

  // IRQ limited to sources above the serviced level
  logic irq_d;
  always_comb begin
    irq_d = 1'b0;
    if (cur_q >= LevelNone) begin
      irq_d = |irqs;
    end else begin
      for (int k = 0; k < NumVectors; k++) begin
        if ((LW'(k) < cur_q) && ctrl_q[k][CTRL_EN_BIT]) begin
          irq_d = irq_d | irqs[ctrl_q[k][4:0]];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      irq_q <= 1'b0;
      fiq_q <= 1'b0;
    end else if (cmd_i.report) begin
      irq_q <= irq_d;
      fiq_q <= |(all_lines & fiqm_q);
    end
  end

  assign read_data_o  = rdata_q;
  assign bad_offset_o = bad_q;
  assign irq_out_o    = irq_q;
  assign fiq_out_o    = fiq_q;

endmodule

// File: rtl/vic_checker.sv
// ----------------------------------------------------------------------------
// vic_checker: port-level checks of the interrupt controller
// Busy on accept, accept-to-result latency, strobe shape and not busy at done; bound to the top level.
// ----------------------------------------------------------------------------
module vic_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  // an accepted item makes the block busy
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accept");

  // result strobe follows accept after the evaluate, apply and report steps
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##4 done_o)
    else $error("result latency wrong");

  // strobe lasts one cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  // a result is shown only once the item is finished
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("done while busy");

endmodule

bind vectored_interrupt_controller vic_checker u_checker (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);
